[rtl/screen_rle_pixel_decoder_core_macros.svh]
// assertion macros used by the checker file srle_checker.sv
`ifndef SCREEN_RLE_PIXEL_DECODER_CORE_MACROS_SVH
`define SCREEN_RLE_PIXEL_DECODER_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define SRLE_ASSERT_SAME(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed in %m");

// next-cycle implication, disabled while in reset
`define SRLE_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed in %m");

`endif

[rtl/srle_pkg.sv]
package srle_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int BYTE_W     = 8;
    localparam int BPP_W      = 3;
    localparam int DIM_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int OFF_W      = 26;
    localparam int PTR_W      = 27;
    localparam int CNT_W      = 8;
    localparam int VAL_W      = 32;
    localparam int CODE_W     = 2;
    localparam int COL_W      = 20;
    localparam int ROW_W      = 16;
    localparam int BIP_W      = 2;
    localparam int STRIDE_W   = 15;
    localparam int LIM_FULL_W = DIM_W + STRIDE_W;
    localparam int PROD_W     = ROW_W + DIM_W;
    localparam int PROD_B_W   = PROD_W + BPP_W;
    localparam int COL_B_W    = COL_W + BPP_W;
    localparam int SEEK_W     = PROD_B_W + 1;
    localparam int REM_W      = 10;
    localparam int NEED_W     = CNT_W + BPP_W;
    localparam int SETTLE_W   = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BPP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    localparam logic [BPP_W-1:0] BPP_RESET    = 3'd1;
    localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [BPP_W-1:0] BPP_MIN      = 3'd1;
    localparam logic [BPP_W-1:0] BPP_MAX      = 3'd4;
    localparam logic [DIM_W-1:0] DIM_MIN      = 13'd1;
    localparam logic [DIM_W-1:0] WIDTH_MAX    = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] HEIGHT_MAX   = DIM_W'(MAX_HEIGHT);

    // end codes on the result
    localparam logic [CODE_W-1:0] END_NONE  = 2'd0;
    localparam logic [CODE_W-1:0] END_FRAME = 2'd1;
    localparam logic [CODE_W-1:0] END_TRUNC = 2'd2;

    // codes after an escape byte
    localparam logic [BYTE_W-1:0] ESC_LINE  = 8'd0;
    localparam logic [BYTE_W-1:0] ESC_FRAME = 8'd1;
    localparam logic [BYTE_W-1:0] ESC_DELTA = 8'd2;

    // x/3 == (x * 683) >> 11 for x below 1024
    localparam logic [REM_W-1:0] DIV3_MUL   = 10'd683;
    localparam int               DIV3_SHIFT = 11;

    localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_RUN_START,
        OP_LIT_START,
        OP_LINE_END,
        OP_DX,
        OP_DY,
        OP_FILL_BYTE,
        OP_LIT_BYTE,
        OP_SEEK1,
        OP_SEEK2,
        OP_FIT,
        OP_DIV,
        OP_WRITE
    } dp_op_t;

    typedef struct packed {
        dp_op_t              op;
        logic                clear;
        logic                emit;
        logic                with_write;
        logic [CODE_W-1:0]   code;
    } dp_cmd_t;

    typedef struct packed {
        logic byte_zero;
        logic byte_frame;
        logic byte_delta;
        logic last;
        logic pixel_done;
        logic lit_last;
        logic pad_pending;
        logic out_free;
    } dp_stat_t;

endpackage

[rtl/srle_in_if.sv]
interface srle_in_if;
    import srle_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] stream_byte;
    logic              last_byte;

    modport source (output valid, output stream_byte, output last_byte, input ready);
    modport sink (input valid, input stream_byte, input last_byte, output ready);
endinterface

[rtl/srle_out_if.sv]
interface srle_out_if;
    import srle_pkg::*;

    logic              valid;
    logic              ready;
    logic              write_valid;
    logic [OFF_W-1:0]  byte_offset;
    logic [CNT_W-1:0]  pixel_count;
    logic [VAL_W-1:0]  pixel_value;
    logic [CODE_W-1:0] end_code;

    modport source (
        output valid, output write_valid, output byte_offset, output pixel_count,
        output pixel_value, output end_code, input ready
    );
    modport sink (
        input valid, input write_valid, input byte_offset, input pixel_count,
        input pixel_value, input end_code, output ready
    );
endinterface

[rtl/srle_controller.sv]
module srle_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               cfg_we,
    input  srle_pkg::dp_stat_t stat,
    output srle_pkg::dp_cmd_t  cmd
);
    import srle_pkg::*;

    typedef enum logic [3:0] {
        S_CMD,
        S_ESC,
        S_DX,
        S_DY,
        S_FILL,
        S_LIT,
        S_PAD,
        S_SEEK1,
        S_SEEK2,
        S_FIT,
        S_DIV,
        S_WRITE,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    state_t              after_reg, after_next;
    logic                last_reg, last_next;
    logic [SETTLE_W-1:0] settle_reg, settle_next;
    logic                accepting;
    logic                acc;
    logic                pix_end;

    always_comb
    begin
        accepting = (state_reg == S_CMD) || (state_reg == S_ESC) || (state_reg == S_DX)
                 || (state_reg == S_DY) || (state_reg == S_FILL) || (state_reg == S_LIT)
                 || (state_reg == S_PAD) || (state_reg == S_DONE);
        in_ready  = accepting && (settle_reg == '0) && stat.out_free;
        acc       = in_valid && in_ready;
        pix_end   = ((state_reg == S_FILL) || (state_reg == S_LIT)) && stat.pixel_done;
    end

    always_comb
    begin
        state_next = state_reg;
        after_next = after_reg;
        last_next  = last_reg;
        cmd        = '0;
        cmd.op     = OP_NONE;
        cmd.code   = END_NONE;

        if (cfg_we)
        begin
            settle_next = SETTLE_CYCLES;
        end
        else if (settle_reg != '0)
        begin
            settle_next = settle_reg - SETTLE_W'(1);
        end
        else
        begin
            settle_next = settle_reg;
        end

        unique case (state_reg)
            S_CMD:
            begin
                if (acc)
                begin
                    if (stat.byte_zero)
                    begin
                        state_next = S_ESC;
                    end
                    else
                    begin
                        cmd.op     = OP_RUN_START;
                        state_next = S_FILL;
                    end
                end
            end
            S_ESC:
            begin
                if (acc)
                begin
                    if (stat.byte_zero)
                    begin
                        cmd.op     = OP_LINE_END;
                        state_next = S_SEEK1;
                    end
                    else if (stat.byte_frame)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.code   = END_FRAME;
                        state_next = S_DONE;
                    end
                    else if (stat.byte_delta)
                    begin
                        state_next = S_DX;
                    end
                    else
                    begin
                        cmd.op     = OP_LIT_START;
                        state_next = S_LIT;
                    end
                end
            end
            S_DX:
            begin
                if (acc)
                begin
                    cmd.op     = OP_DX;
                    state_next = S_DY;
                end
            end
            S_DY:
            begin
                if (acc)
                begin
                    cmd.op     = OP_DY;
                    state_next = S_SEEK1;
                end
            end
            S_FILL:
            begin
                if (acc)
                begin
                    cmd.op = OP_FILL_BYTE;
                    if (stat.pixel_done)
                    begin
                        state_next = S_FIT;
                        after_next = S_CMD;
                        last_next  = stat.last;
                    end
                end
            end
            S_LIT:
            begin
                if (acc)
                begin
                    cmd.op = OP_LIT_BYTE;
                    if (stat.pixel_done)
                    begin
                        state_next = S_FIT;
                        last_next  = stat.last;
                        if (!stat.lit_last)
                        begin
                            after_next = S_LIT;
                        end
                        else if (stat.pad_pending)
                        begin
                            after_next = S_PAD;
                        end
                        else
                        begin
                            after_next = S_CMD;
                        end
                    end
                end
            end
            S_PAD:
            begin
                if (acc)
                begin
                    state_next = S_CMD;
                end
            end
            S_SEEK1:
            begin
                cmd.op     = OP_SEEK1;
                state_next = S_SEEK2;
            end
            S_SEEK2:
            begin
                cmd.op     = OP_SEEK2;
                state_next = S_CMD;
            end
            S_FIT:
            begin
                cmd.op     = OP_FIT;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op     = OP_DIV;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                if (stat.out_free)
                begin
                    cmd.op         = OP_WRITE;
                    cmd.emit       = 1'b1;
                    cmd.with_write = 1'b1;
                    cmd.code       = last_reg ? END_TRUNC : END_NONE;
                    cmd.clear      = last_reg;
                    state_next     = last_reg ? S_CMD : after_reg;
                end
            end
            S_DONE:
            begin
                // bytes after the end code are dropped until the frame's last byte
                if (acc && stat.last)
                begin
                    cmd.clear  = 1'b1;
                    state_next = S_CMD;
                end
            end
            default:
            begin
                state_next = S_CMD;
            end
        endcase

        // last byte that does not finish a pixel: report and start a new frame
        if (acc && stat.last && (state_reg != S_DONE) && !pix_end)
        begin
            cmd.op     = OP_NONE;
            cmd.clear  = 1'b1;
            cmd.emit   = 1'b1;
            cmd.code   = ((state_reg == S_ESC) && stat.byte_frame) ? END_FRAME : END_TRUNC;
            state_next = S_CMD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CMD;
            after_reg  <= S_CMD;
            last_reg   <= 1'b0;
            settle_reg <= SETTLE_CYCLES;
        end
        else
        begin
            state_reg  <= state_next;
            after_reg  <= after_next;
            last_reg   <= last_next;
            settle_reg <= settle_next;
        end
    end

endmodule

[rtl/srle_datapath.sv]
module srle_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [srle_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [srle_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [srle_pkg::BYTE_W-1:0]       in_byte,
    input  logic                              in_last,
    input  srle_pkg::dp_cmd_t                 cmd,
    output srle_pkg::dp_stat_t                stat,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic                              out_write_valid,
    output logic [srle_pkg::OFF_W-1:0]        out_byte_offset,
    output logic [srle_pkg::CNT_W-1:0]        out_pixel_count,
    output logic [srle_pkg::VAL_W-1:0]        out_pixel_value,
    output logic [srle_pkg::CODE_W-1:0]       out_end_code
);
    import srle_pkg::*;

    // configuration
    logic [BPP_W-1:0]      bpp_reg;
    logic [DIM_W-1:0]      width_reg;
    logic [DIM_W-1:0]      height_reg;
    logic [BPP_W-1:0]      eff_bpp;
    logic [DIM_W-1:0]      eff_width;
    logic [DIM_W-1:0]      eff_height;
    logic [STRIDE_W-1:0]   line_bytes;
    logic [STRIDE_W-1:0]   stride_next;
    logic [STRIDE_W-1:0]   stride_reg;
    logic [LIM_FULL_W-1:0] lim_full;
    logic [PTR_W-1:0]      limit_reg;

    // frame parse state
    logic [CNT_W-1:0]      pending_reg;
    logic [VAL_W-1:0]      accum_reg;
    logic [BIP_W-1:0]      bip_reg;
    logic                  pad_reg;
    logic [COL_W-1:0]      col_reg;
    logic [ROW_W-1:0]      row_reg;
    logic [PTR_W-1:0]      wp_reg;

    // per-write work registers
    logic [VAL_W-1:0]      value_reg;
    logic [CNT_W-1:0]      run_len_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic                  fit_all_reg;
    logic [REM_W-1:0]      rem_lo_reg;
    logic [CNT_W-1:0]      cnt_reg;

    logic [BPP_W-1:0]      bip_plus;
    logic                  pixel_done;
    logic [VAL_W-1:0]      accum_new;
    logic [PROD_B_W-1:0]   prod_b;
    logic [COL_B_W-1:0]    col_b;
    logic [SEEK_W-1:0]     seek_off;
    logic [PTR_W-1:0]      seek_clamped;
    logic                  over;
    logic [PTR_W-1:0]      rem;
    logic [NEED_W-1:0]     need;
    logic                  fit_all;
    logic [2*REM_W-1:0]    rem3;
    logic [CNT_W-1:0]      div_q;
    logic [CNT_W-1:0]      cnt_next;
    logic [NEED_W-1:0]     cnt_bytes;
    logic                  has_write;
    logic                  out_load;

    logic                  out_valid_reg;
    logic                  out_write_valid_reg;
    logic [OFF_W-1:0]      out_byte_offset_reg;
    logic [CNT_W-1:0]      out_pixel_count_reg;
    logic [VAL_W-1:0]      out_pixel_value_reg;
    logic [CODE_W-1:0]     out_end_code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg    <= BPP_RESET;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BPP:    bpp_reg    <= cfg_data[BPP_W-1:0];
                CFG_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        if (bpp_reg == '0)
        begin
            eff_bpp = BPP_MIN;
        end
        else if (bpp_reg > BPP_MAX)
        begin
            eff_bpp = BPP_MAX;
        end
        else
        begin
            eff_bpp = bpp_reg;
        end

        if (width_reg == '0)
        begin
            eff_width = DIM_MIN;
        end
        else if (width_reg > WIDTH_MAX)
        begin
            eff_width = WIDTH_MAX;
        end
        else
        begin
            eff_width = width_reg;
        end

        if (height_reg == '0)
        begin
            eff_height = DIM_MIN;
        end
        else if (height_reg > HEIGHT_MAX)
        begin
            eff_height = HEIGHT_MAX;
        end
        else
        begin
            eff_height = height_reg;
        end

        // line rounded up to whole 32-bit words
        line_bytes  = STRIDE_W'(eff_width) * STRIDE_W'(eff_bpp);
        stride_next = (line_bytes + STRIDE_W'(3)) & ~STRIDE_W'(3);
        lim_full    = LIM_FULL_W'(eff_height) * LIM_FULL_W'(stride_reg);
    end

    // frame byte limit settles after a register write, through stride_reg and then limit_reg
    always_ff @(posedge clk)
    begin
        stride_reg <= stride_next;
        limit_reg  <= lim_full[PTR_W-1:0];
    end

    always_comb
    begin
        bip_plus   = BPP_W'(bip_reg) + BPP_W'(1);
        pixel_done = bip_plus >= eff_bpp;
        accum_new  = accum_reg | (VAL_W'(in_byte) << {bip_reg, 3'b000});

        prod_b       = PROD_B_W'(prod_reg) * PROD_B_W'(eff_bpp);
        col_b        = COL_B_W'(col_reg) * COL_B_W'(eff_bpp);
        seek_off     = SEEK_W'(prod_b) + SEEK_W'(col_b);
        seek_clamped = (seek_off > SEEK_W'(limit_reg)) ? limit_reg : seek_off[PTR_W-1:0];

        over    = wp_reg >= limit_reg;
        rem     = limit_reg - wp_reg;
        need    = NEED_W'(run_len_reg) * NEED_W'(eff_bpp);
        fit_all = !over && (rem >= PTR_W'(need));

        // a cut run leaves less than 1024 bytes, so a short divide suffices
        rem3 = (2*REM_W)'(rem_lo_reg) * (2*REM_W)'(DIV3_MUL);
        unique case (eff_bpp)
            3'd1:    div_q = rem_lo_reg[CNT_W-1:0];
            3'd2:    div_q = rem_lo_reg[CNT_W:1];
            3'd3:    div_q = rem3[DIV3_SHIFT+CNT_W-1:DIV3_SHIFT];
            default: div_q = rem_lo_reg[CNT_W+1:2];
        endcase
        cnt_next = fit_all_reg ? run_len_reg : div_q;

        cnt_bytes = NEED_W'(cnt_reg) * NEED_W'(eff_bpp);
        has_write = cmd.with_write && (cnt_reg != '0);
        out_load  = cmd.emit && (has_write || (cmd.code != END_NONE));

        stat.byte_zero   = in_byte == ESC_LINE;
        stat.byte_frame  = in_byte == ESC_FRAME;
        stat.byte_delta  = in_byte == ESC_DELTA;
        stat.last        = in_last;
        stat.pixel_done  = pixel_done;
        stat.lit_last    = pending_reg == CNT_W'(1);
        stat.pad_pending = pad_reg;
        stat.out_free    = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            accum_reg   <= '0;
            bip_reg     <= '0;
            pad_reg     <= 1'b0;
            col_reg     <= '0;
            row_reg     <= '0;
            wp_reg      <= '0;
        end
        else if (cmd.clear)
        begin
            pending_reg <= '0;
            accum_reg   <= '0;
            bip_reg     <= '0;
            pad_reg     <= 1'b0;
            col_reg     <= '0;
            row_reg     <= '0;
            wp_reg      <= '0;
        end
        else
        begin
            unique case (cmd.op)
                OP_RUN_START:
                begin
                    pending_reg <= in_byte;
                    accum_reg   <= '0;
                    bip_reg     <= '0;
                end
                OP_LIT_START:
                begin
                    pending_reg <= in_byte;
                    pad_reg     <= (eff_bpp == BPP_MIN) && in_byte[0];
                    accum_reg   <= '0;
                    bip_reg     <= '0;
                end
                OP_LINE_END:
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + ROW_W'(1);
                end
                OP_DX:
                begin
                    col_reg <= col_reg + COL_W'(in_byte);
                end
                OP_DY:
                begin
                    row_reg <= row_reg + ROW_W'(in_byte);
                end
                OP_FILL_BYTE:
                begin
                    if (pixel_done)
                    begin
                        accum_reg <= '0;
                        bip_reg   <= '0;
                        col_reg   <= col_reg + COL_W'(pending_reg);
                    end
                    else
                    begin
                        accum_reg <= accum_new;
                        bip_reg   <= bip_plus[BIP_W-1:0];
                    end
                end
                OP_LIT_BYTE:
                begin
                    if (pixel_done)
                    begin
                        accum_reg   <= '0;
                        bip_reg     <= '0;
                        col_reg     <= col_reg + COL_W'(1);
                        pending_reg <= pending_reg - CNT_W'(1);
                        if (pending_reg == CNT_W'(1))
                        begin
                            pad_reg <= 1'b0;
                        end
                    end
                    else
                    begin
                        accum_reg <= accum_new;
                        bip_reg   <= bip_plus[BIP_W-1:0];
                    end
                end
                OP_SEEK2:
                begin
                    wp_reg <= seek_clamped;
                end
                OP_WRITE:
                begin
                    wp_reg <= wp_reg + PTR_W'(cnt_bytes);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (((cmd.op == OP_FILL_BYTE) || (cmd.op == OP_LIT_BYTE)) && pixel_done)
        begin
            value_reg   <= accum_new;
            run_len_reg <= (cmd.op == OP_FILL_BYTE) ? pending_reg : CNT_W'(1);
        end
        if (cmd.op == OP_SEEK1)
        begin
            prod_reg <= PROD_W'(row_reg) * PROD_W'(eff_width);
        end
        if (cmd.op == OP_FIT)
        begin
            fit_all_reg <= fit_all;
            rem_lo_reg  <= over ? '0 : rem[REM_W-1:0];
        end
        if (cmd.op == OP_DIV)
        begin
            cnt_reg <= cnt_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_write_valid_reg <= has_write;
            out_byte_offset_reg <= has_write ? wp_reg[OFF_W-1:0] : '0;
            out_pixel_count_reg <= has_write ? cnt_reg : '0;
            out_pixel_value_reg <= has_write ? value_reg : '0;
            out_end_code_reg    <= cmd.code;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_write_valid = out_write_valid_reg;
    assign out_byte_offset = out_byte_offset_reg;
    assign out_pixel_count = out_pixel_count_reg;
    assign out_pixel_value = out_pixel_value_reg;
    assign out_end_code    = out_end_code_reg;

endmodule

[rtl/screen_rle_pixel_decoder_core.sv]
// Run-length frame decoder: takes the inflated stream one word (byte) per handshake and
// gives frame-buffer writes as (byte offset, pixel count, pixel value) plus an end code.
// A byte that completes a pixel holds the parser for the room check against the
// frame byte limit, the cut of the run to whole pixels and the write, which waits for
// the output register to be free. An end-of-line or position-delta command adds the row
// offset multiply and the clamp to the limit. After reset and after every register
// write the input stays not ready while the stride and frame byte limit are
// recomputed. Results wait in an output register; an input byte is accepted while an
// earlier result is still held there only if that result is taken in the same cycle.
module screen_rle_pixel_decoder_core (
    input  logic                            clk,
    input  logic                            rst_n,
    srle_in_if.sink                         stream_in,
    srle_out_if.source                      write_out,
    input  logic                            cfg_we,
    input  logic [srle_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [srle_pkg::CFG_DATA_W-1:0] cfg_data
);
    import srle_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    srle_controller u_controller (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (stream_in.valid),
        .in_ready (stream_in.ready),
        .cfg_we   (cfg_we),
        .stat     (stat),
        .cmd      (cmd)
    );

    srle_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_byte         (stream_in.stream_byte),
        .in_last         (stream_in.last_byte),
        .cmd             (cmd),
        .stat            (stat),
        .out_ready       (write_out.ready),
        .out_valid       (write_out.valid),
        .out_write_valid (write_out.write_valid),
        .out_byte_offset (write_out.byte_offset),
        .out_pixel_count (write_out.pixel_count),
        .out_pixel_value (write_out.pixel_value),
        .out_end_code    (write_out.end_code)
    );

endmodule

[rtl/srle_checker.sv]
`include "screen_rle_pixel_decoder_core_macros.svh"

module srle_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_ready,
    input logic                          cfg_we,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          out_write_valid,
    input logic [srle_pkg::OFF_W-1:0]    out_byte_offset,
    input logic [srle_pkg::CNT_W-1:0]    out_pixel_count,
    input logic [srle_pkg::VAL_W-1:0]    out_pixel_value,
    input logic [srle_pkg::CODE_W-1:0]   out_end_code
);
    import srle_pkg::*;

    `SRLE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

    // every result carries a write or an end code
    `SRLE_ASSERT_SAME(a_result_nonempty, clk, rst_n, out_valid, out_write_valid || out_end_code != END_NONE)

    `SRLE_ASSERT_SAME(a_write_count, clk, rst_n, out_valid && out_write_valid, out_pixel_count != '0)

    `SRLE_ASSERT_SAME(a_idle_payload, clk, rst_n, out_valid && !out_write_valid, out_byte_offset == '0 && out_pixel_count == '0 && out_pixel_value == '0)

    // input is held off while the frame limit is recomputed
    `SRLE_ASSERT_NEXT(a_cfg_holdoff, clk, rst_n, cfg_we, !in_ready)

endmodule

bind screen_rle_pixel_decoder_core srle_checker u_srle_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ready        (stream_in.ready),
    .cfg_we          (cfg_we),
    .out_valid       (write_out.valid),
    .out_ready       (write_out.ready),
    .out_write_valid (write_out.write_valid),
    .out_byte_offset (write_out.byte_offset),
    .out_pixel_count (write_out.pixel_count),
    .out_pixel_value (write_out.pixel_value),
    .out_end_code    (write_out.end_code)
);
